/* design/bfsa_pkg.sv */
package bfsa_pkg;

    // Table size default
    localparam int MAX_SEGMENTS_DEF = 64;

    // Field widths
    localparam int START_W = 16;
    localparam int LEN_W   = 17;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 3;

    // Largest managed memory
    localparam logic [LEN_W-1:0] MEM_CAP = 17'h10000;

    // Stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 72;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd2;
    localparam logic [OP_W-1:0] OP_COMPACT = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FIT    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DUP_ID    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

    // One table entry
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               in_use;
        logic [ID_W-1:0]    owner;
        logic [TIME_W-1:0]  time_left;
    } seg_t;

endpackage

/* design/bfsa_seg_table.sv */
module bfsa_seg_table
    import bfsa_pkg::*;
#(
    parameter int DEPTH = 2 * MAX_SEGMENTS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  seg_t                     wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output seg_t                     rd_data
);

    seg_t ram_reg [DEPTH];
    seg_t rd_data_reg;

    // Write one entry, read one entry, registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/best_fit_segment_allocator.sv */
// Best-fit segment allocator. The segment table lives in a two-bank RAM; every
// operation rebuilds the table from one bank into the other, one entry at a
// time through a single shared evaluate/merge unit, then flips banks. A process
// that follows a pending hole takes an extra step to write both. Before the
// rebuild, allocate first scans the table for the best hole and owner match
// at one entry a cycle. The block takes one operation at a time and is ready
// again once its result sits in the output register. After reset, and after
// each memory_words write taken while idle, the init state initialises the
// table.
module best_fit_segment_allocator
    import bfsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: opcode[2:0], process_id[18:3], request_size[35:19],
    //          run_time[67:36], time_step[99:68]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: status[2:0], placed_at[18:3], best_hole_size[35:19],
    //          best_hole_start[51:36], free_words[68:52], id_present[69],
    //          any_process[70]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int TW = IW + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_RD     = 3'd3;
    localparam logic [2:0] ST_EVAL   = 3'd4;
    localparam logic [2:0] ST_EXTRA  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic               bank_reg, bank_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [LEN_W-1:0]   mem_words_reg, mem_words_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [LEN_W-1:0]   size_reg, size_next;
    logic [TIME_W-1:0]  run_reg, run_next;
    logic [TIME_W-1:0]  step_reg, step_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      w_reg, w_next;
    logic               dv_reg, dv_next;
    logic [IW-1:0]      didx_reg, didx_next;
    logic [IW-1:0]      b_idx_reg, b_idx_next;
    logic               dup_reg, dup_next;
    logic               alloc_ok_reg, alloc_ok_next;
    logic [STAT_W-1:0]  stat_reg, stat_next;
    logic               found_reg, found_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    seg_t               pend_reg, pend_next;
    logic               pend_v_reg, pend_v_next;
    seg_t               hold_reg, hold_next;
    seg_t               hold_rem_reg, hold_rem_next;
    logic               hold_rem_v_reg, hold_rem_v_next;
    logic               bf_v_reg, bf_v_next;
    logic [LEN_W-1:0]   bf_len_reg, bf_len_next;
    logic [START_W-1:0] bf_start_reg, bf_start_next;
    logic [START_W-1:0] placed_reg, placed_next;
    logic [LEN_W-1:0]   used_reg, used_next;
    logic               idp_reg, idp_next;
    logic               anyp_reg, anyp_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               wr_en;
    logic [TW-1:0]      wr_addr;
    seg_t               wr_data;
    logic [TW-1:0]      rd_addr;
    seg_t               rd_data;

    seg_t               ent;
    seg_t               rem_hole;
    logic [LEN_W-1:0]   rem;
    logic               hit;
    logic               rem_v;
    logic               cfg_wr;
    logic [LEN_W-1:0]   cfg_val;
    logic [STAT_W-1:0]  out_stat;
    logic [LEN_W-1:0]   free_words;

    bfsa_seg_table #(
        .DEPTH(2 ** TW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata  = (paddr[2] == 1'b0) ? {15'd0, mem_words_reg} : 32'd0;

    always_comb begin
        cfg_val = pwdata[LEN_W-1:0];
        if (cfg_val == '0) begin
            cfg_val = LEN_W'(1);
        end else if (cfg_val > MEM_CAP) begin
            cfg_val = MEM_CAP;
        end
    end

    // Take input beats only while idle; hold them off while a register write is taken
    assign s_tready = (state_reg == ST_IDLE) && !cfg_wr;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign free_words = mem_words_reg - used_reg;

    // Sequencer and shared evaluate unit
    always_comb begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        count_next      = count_reg;
        mem_words_next  = mem_words_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        size_next       = size_reg;
        run_next        = run_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        w_next          = w_reg;
        dv_next         = 1'b0;
        didx_next       = didx_reg;
        b_idx_next      = b_idx_reg;
        dup_next        = dup_reg;
        alloc_ok_next   = alloc_ok_reg;
        stat_next       = stat_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        pend_v_next     = pend_v_reg;
        hold_next       = hold_reg;
        hold_rem_next   = hold_rem_reg;
        hold_rem_v_next = hold_rem_v_reg;
        bf_v_next       = bf_v_reg;
        bf_len_next     = bf_len_reg;
        bf_start_next   = bf_start_reg;
        placed_next     = placed_reg;
        used_next       = used_reg;
        idp_next        = idp_reg;
        anyp_next       = anyp_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        wr_en           = 1'b0;
        wr_addr         = {~bank_reg, w_reg[IW-1:0]};
        wr_data         = rd_data;
        rd_addr         = {bank_reg, idx_reg[IW-1:0]};
        out_stat        = stat_reg;

        // Current entry through the shared unit
        ent      = rd_data;
        rem      = rd_data.len - size_reg;
        hit      = alloc_ok_reg && (idx_reg[IW-1:0] == b_idx_reg);
        rem_v    = hit && (rem != '0);
        rem_hole = '0;
        rem_hole.start = rd_data.start + size_reg[START_W-1:0];
        rem_hole.len   = rem;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                wr_en         = 1'b1;
                wr_addr       = {bank_reg, {IW{1'b0}}};
                wr_data       = '0;
                wr_data.len   = mem_words_reg;
                count_next    = CW'(1);
                state_next    = ST_IDLE;
            end
            ST_IDLE: begin
                if (cfg_wr) begin
                    mem_words_next = cfg_val;
                    state_next     = ST_INIT;
                end else if (s_tvalid) begin
                    op_next       = s_tdata[2:0];
                    id_next       = s_tdata[18:3];
                    size_next     = s_tdata[35:19];
                    run_next      = s_tdata[67:36];
                    step_next     = s_tdata[99:68];
                    idx_next      = '0;
                    w_next        = '0;
                    pend_v_next   = 1'b0;
                    found_next    = 1'b0;
                    pos_next      = '0;
                    bf_v_next     = 1'b0;
                    dup_next      = 1'b0;
                    used_next     = '0;
                    idp_next      = 1'b0;
                    anyp_next     = 1'b0;
                    alloc_ok_next = 1'b0;
                    placed_next   = '0;
                    stat_next     = STAT_OK;
                    state_next    = (s_tdata[2:0] == OP_ALLOC) ? ST_SCAN : ST_RD;
                end
            end
            ST_SCAN: begin
                // Issue one read a cycle, judge each entry in the cycle after its read
                if (idx_reg < count_reg) begin
                    idx_next  = idx_reg + CW'(1);
                    dv_next   = 1'b1;
                    didx_next = idx_reg[IW-1:0];
                end
                if (dv_reg) begin
                    if (ent.in_use && (ent.owner == id_reg)) begin
                        dup_next = 1'b1;
                    end
                    if (!ent.in_use && (ent.len >= size_reg)
                        && (!bf_v_reg || (ent.len < bf_len_reg))) begin
                        bf_v_next   = 1'b1;
                        bf_len_next = ent.len;
                        b_idx_next  = didx_reg;
                    end
                end else if (!(idx_reg < count_reg)) begin
                    if (dup_reg) begin
                        stat_next = STAT_DUP_ID;
                    end else if ((size_reg == '0) || !bf_v_reg) begin
                        stat_next = STAT_NO_FIT;
                    end else if ((bf_len_reg != size_reg) && (count_reg >= MAX_CNT)) begin
                        stat_next = STAT_FULL;
                    end else begin
                        alloc_ok_next = 1'b1;
                    end
                    bf_v_next  = 1'b0;
                    idx_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = (idx_reg < count_reg) ? ST_EVAL : ST_FINISH;
            end
            ST_EVAL: begin
                case (op_reg)
                    OP_ALLOC: begin
                        if (hit) begin
                            ent.in_use    = 1'b1;
                            ent.owner     = id_reg;
                            ent.time_left = run_reg;
                            ent.len       = size_reg;
                            placed_next   = rd_data.start;
                        end
                    end
                    OP_FREE: begin
                        if (rd_data.in_use && (rd_data.owner == id_reg) && !found_reg) begin
                            ent.in_use = 1'b0;
                            found_next = 1'b1;
                        end
                    end
                    OP_ADVANCE: begin
                        if (rd_data.in_use) begin
                            if (rd_data.time_left <= step_reg) begin
                                ent.in_use = 1'b0;
                            end else begin
                                ent.time_left = rd_data.time_left - step_reg;
                            end
                        end
                    end
                    OP_COMPACT: begin
                        ent.start = pos_reg[START_W-1:0];
                    end
                    default: begin
                    end
                endcase
                idx_next   = idx_reg + CW'(1);
                state_next = ST_RD;
                if (op_reg == OP_COMPACT) begin
                    // Drop holes, pack processes down
                    if (ent.in_use) begin
                        wr_en    = 1'b1;
                        wr_data  = ent;
                        pos_next = pos_reg + ent.len;
                    end
                end else if (!ent.in_use) begin
                    // Merge holes into the pending one
                    if (pend_v_reg) begin
                        pend_next.len = pend_reg.len + ent.len;
                    end else begin
                        pend_next   = ent;
                        pend_v_next = 1'b1;
                    end
                end else if (pend_v_reg) begin
                    wr_en           = 1'b1;
                    wr_data         = pend_reg;
                    pend_v_next     = 1'b0;
                    hold_next       = ent;
                    hold_rem_next   = rem_hole;
                    hold_rem_v_next = rem_v;
                    state_next      = ST_EXTRA;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = ent;
                    if (rem_v) begin
                        pend_next   = rem_hole;
                        pend_v_next = 1'b1;
                    end
                end
            end
            ST_EXTRA: begin
                wr_en       = 1'b1;
                wr_data     = hold_reg;
                pend_next   = hold_rem_reg;
                pend_v_next = hold_rem_v_reg;
                state_next  = ST_RD;
            end
            ST_FINISH: begin
                // Close the table: top hole or last pending hole
                if (op_reg == OP_COMPACT) begin
                    if ((pos_reg < mem_words_reg) && (w_reg < MAX_CNT)) begin
                        wr_en         = 1'b1;
                        wr_data       = '0;
                        wr_data.start = pos_reg[START_W-1:0];
                        wr_data.len   = mem_words_reg - pos_reg;
                    end
                end else if (pend_v_reg) begin
                    wr_en   = 1'b1;
                    wr_data = pend_reg;
                end
                count_next = w_reg + (wr_en ? CW'(1) : CW'(0));
                bank_next  = ~bank_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if ((op_reg == OP_FREE) && !found_reg) begin
                    out_stat = STAT_NOT_FOUND;
                end
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, anyp_reg, idp_reg, free_words,
                                     bf_v_reg ? bf_start_reg : {START_W{1'b0}},
                                     bf_v_reg ? bf_len_reg : {LEN_W{1'b0}},
                                     placed_reg, out_stat};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Track what each rebuilt entry leaves in the table
        if (wr_en && (state_reg != ST_INIT)) begin
            w_next = w_reg + CW'(1);
            if (wr_data.in_use) begin
                used_next = used_reg + wr_data.len;
                anyp_next = 1'b1;
                if (wr_data.owner == id_reg) begin
                    idp_next = 1'b1;
                end
            end else if ((wr_data.len >= size_reg)
                         && (!bf_v_reg || (wr_data.len < bf_len_reg))) begin
                bf_v_next     = 1'b1;
                bf_len_next   = wr_data.len;
                bf_start_next = wr_data.start;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            bank_reg      <= 1'b0;
            count_reg     <= CW'(1);
            mem_words_reg <= MEM_CAP;
            m_tvalid_reg  <= 1'b0;
            dv_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            count_reg     <= count_next;
            mem_words_reg <= mem_words_next;
            m_tvalid_reg  <= m_tvalid_next;
            dv_reg        <= dv_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        size_reg       <= size_next;
        run_reg        <= run_next;
        step_reg       <= step_next;
        idx_reg        <= idx_next;
        w_reg          <= w_next;
        didx_reg       <= didx_next;
        b_idx_reg      <= b_idx_next;
        dup_reg        <= dup_next;
        alloc_ok_reg   <= alloc_ok_next;
        stat_reg       <= stat_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        pend_reg       <= pend_next;
        pend_v_reg     <= pend_v_next;
        hold_reg       <= hold_next;
        hold_rem_reg   <= hold_rem_next;
        hold_rem_v_reg <= hold_rem_v_next;
        bf_v_reg       <= bf_v_next;
        bf_len_reg     <= bf_len_next;
        bf_start_reg   <= bf_start_next;
        placed_reg     <= placed_next;
        used_reg       <= used_next;
        idp_reg        <= idp_next;
        anyp_reg       <= anyp_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

/* design/bfsa_checker.sv */
module bfsa_checker
    import bfsa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Busy after taking an operation
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready straight after an accepted beat");

    // Status code in range
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= STAT_FULL))
        else $error("status code out of range");

    // Free words never exceed the memory cap
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[68:52] <= MEM_CAP))
        else $error("free words beyond memory size");

    // An owned id implies a process exists
    a_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[69] |-> m_tdata[70])
        else $error("id present without any process");

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
